// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition in one cycle implies another in the next cycle
`define ASSERT_NEXT(label, cond, expect_next, msg) \
    `ASSERT_CLK(label, (cond) |=> (expect_next), msg)

`endif

// ===== hdl/hss_pkg.sv =====
// shared constants, types and stage codes for the heun state step core
`timescale 1ns / 1ps

package hss_pkg;

    localparam int ENTRIES     = 1024;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int VAL_W       = 32;
    localparam int DT_W        = 24;
    localparam int SUM_OP_W    = VAL_W + 1;
    localparam int PROD_W      = SUM_OP_W + DT_W + 1;
    localparam int FRAC_W      = 16;
    localparam int ACC_W       = PROD_W - FRAC_W;
    localparam int MEM_W       = 3 * VAL_W;

    localparam int IN_DATA_W   = 112;
    localparam int OUT_DATA_W  = 80;
    localparam int STAGE_W     = 2;

    localparam logic [DT_W-1:0] TIME_STEP_RESET = 24'h010000;

    typedef enum logic [STAGE_W-1:0] {
        STAGE_PASS = 2'd0,
        STAGE_PRED = 2'd1,
        STAGE_CORR = 2'd2
    } stage_t;

    typedef struct packed {
        logic en;
        logic halve;
    } lane_ctrl_t;

endpackage

// ===== hdl/heun_second_order_state_step_core.sv =====
// top level: heun rk2 step core with saved state memory and two arithmetic lanes
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------------------
//  s_*       | in  | s_tvalid/tready  | tuser: stage; tdata: index, pos, vel, acc
//  m_*       | out | m_tvalid/tready  | tdata: element, position, velocity
//  cfg_*     | in  | cfg_we           | cfg_wdata: time step, unsigned q8.16
//
//  one word per cycle while the output is not stalled; valid goes v1_reg, v2_reg, v3_reg, m_tvalid_reg
//  stages: memory read, operand select, multiply, shift/add/saturate to output reg
//  a stalled output freezes the whole pipeline; the memory read data holds with it
//  reset clears the valid bits and sets the time step to 1.0; the state memory is not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heun_second_order_state_step_core
    import hss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [DT_W-1:0]       cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // element_index, position_in, velocity_in, acceleration_in
    input  logic [STAGE_W-1:0]    s_tuser,   // stage
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // element_out, position_out, velocity_out
);

    logic [DT_W-1:0]        time_step_reg;

    logic                   advance;
    logic                   accept;

    logic [IDX_W-1:0]       in_idx;
    logic [VAL_W-1:0]       in_pos;
    logic [VAL_W-1:0]       in_vel;
    logic [VAL_W-1:0]       in_acc;

    logic [MEM_W-1:0]       mem [ENTRIES];
    logic [MEM_W-1:0]       rd_data_reg;

    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic [STAGE_W-1:0]     stage1_reg;
    logic [IDX_W-1:0]       idx1_reg;
    logic [IDX_W-1:0]       idx2_reg;
    logic [IDX_W-1:0]       idx3_reg;
    logic signed [VAL_W-1:0] pos1_reg;
    logic signed [VAL_W-1:0] vel1_reg;
    logic signed [VAL_W-1:0] acc1_reg;

    logic signed [VAL_W-1:0] saved_pos;
    logic signed [VAL_W-1:0] saved_vel;
    logic signed [VAL_W-1:0] saved_acc;

    logic signed [VAL_W-1:0]    base_p;
    logic signed [VAL_W-1:0]    base_v;
    logic signed [SUM_OP_W-1:0] operand_p;
    logic signed [SUM_OP_W-1:0] operand_v;
    lane_ctrl_t                 ctrl;
    logic signed [VAL_W-1:0]    res_p;
    logic signed [VAL_W-1:0]    res_v;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [IDX_W-1:0]       out_idx_reg;
    logic [VAL_W-1:0]       out_pos_reg;
    logic [VAL_W-1:0]       out_vel_reg;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_pos = s_tdata[IDX_W +: VAL_W];
    assign in_vel = s_tdata[IDX_W + VAL_W +: VAL_W];
    assign in_acc = s_tdata[IDX_W + 2*VAL_W +: VAL_W];

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_we)
        begin
            time_step_reg <= cfg_wdata;
        end
    end

    // predictor writes on the accept edge, so a later corrector read of the same entry
    // always sees it without forwarding
    always_ff @(posedge clk)
    begin
        if (accept && (s_tuser == STAGE_PRED))
        begin
            mem[in_idx] <= {in_acc, in_vel, in_pos};
        end
        if (accept)
        begin
            rd_data_reg <= mem[in_idx];
        end
    end

    assign saved_pos = rd_data_reg[VAL_W-1:0];
    assign saved_vel = rd_data_reg[VAL_W +: VAL_W];
    assign saved_acc = rd_data_reg[2*VAL_W +: VAL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                v1_reg <= s_tvalid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid_next = advance ? v3_reg : m_tvalid_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage1_reg <= s_tuser;
            idx1_reg   <= in_idx;
            pos1_reg   <= in_pos;
            vel1_reg   <= in_vel;
            acc1_reg   <= in_acc;
            idx2_reg   <= idx1_reg;
            idx3_reg   <= idx2_reg;
        end
        if (advance && v3_reg)
        begin
            out_idx_reg <= idx3_reg;
            out_pos_reg <= res_p;
            out_vel_reg <= res_v;
        end
    end

    // operand select: pass through and the reserved stage code leave a zero product
    always_comb
    begin
        ctrl.en    = advance;
        ctrl.halve = 1'b0;
        base_p     = pos1_reg;
        base_v     = vel1_reg;
        operand_p  = '0;
        operand_v  = '0;
        unique case (stage1_reg)
            STAGE_PRED:
            begin
                operand_p = SUM_OP_W'(vel1_reg);
                operand_v = SUM_OP_W'(acc1_reg);
            end
            STAGE_CORR:
            begin
                ctrl.halve = 1'b1;
                base_p     = saved_pos;
                base_v     = saved_vel;
                operand_p  = SUM_OP_W'(saved_vel) + SUM_OP_W'(vel1_reg);
                operand_v  = SUM_OP_W'(saved_acc) + SUM_OP_W'(acc1_reg);
            end
            default:
            begin
                operand_p = '0;
                operand_v = '0;
            end
        endcase
    end

    hss_lane u_lane_pos (
        .clk       (clk),
        .ctrl      (ctrl),
        .time_step (time_step_reg),
        .base      (base_p),
        .operand   (operand_p),
        .result    (res_p)
    );

    hss_lane u_lane_vel (
        .clk       (clk),
        .ctrl      (ctrl),
        .time_step (time_step_reg),
        .base      (base_v),
        .operand   (operand_v),
        .result    (res_v)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - IDX_W - 2*VAL_W){1'b0}}, out_vel_reg, out_pos_reg, out_idx_reg};

    `ASSERT_NEXT(a_stall_freezes_pipe, m_tvalid && !m_tready, $stable({v1_reg, v2_reg, v3_reg}),
        "pipeline moved while the output word was stalled")
    `ASSERT_NEXT(a_accept_fills_stage1, s_tvalid && s_tready, v1_reg,
        "accepted word did not enter the first stage")
    `ASSERT_NEXT(a_last_stage_reaches_out, v3_reg && advance, m_tvalid,
        "word in the last stage did not reach the output register")

endmodule

// ===== hdl/hss_lane.sv =====
// one multiply, floor shift, add and saturate lane, two register stages deep
`timescale 1ns / 1ps

module hss_lane
    import hss_pkg::*;
(
    input  logic                       clk,
    input  lane_ctrl_t                 ctrl,
    input  logic        [DT_W-1:0]     time_step,
    input  logic signed [VAL_W-1:0]    base,
    input  logic signed [SUM_OP_W-1:0] operand,
    output logic signed [VAL_W-1:0]    result
);

    logic signed [VAL_W-1:0]    base_a_reg;
    logic signed [SUM_OP_W-1:0] operand_a_reg;
    logic                       halve_a_reg;
    logic signed [VAL_W-1:0]    base_b_reg;
    logic signed [PROD_W-1:0]   prod_b_reg;
    logic                       halve_b_reg;

    logic signed [DT_W:0]       dt_s;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_shifted;
    logic signed [ACC_W-1:0]    sum;
    logic                       in_range;

    assign dt_s      = $signed({1'b0, time_step});
    assign prod_next = operand_a_reg * dt_s;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            base_a_reg    <= base;
            operand_a_reg <= operand;
            halve_a_reg   <= ctrl.halve;
            base_b_reg    <= base_a_reg;
            prod_b_reg    <= prod_next;
            halve_b_reg   <= halve_a_reg;
        end
    end

    // arithmetic shift is the floor; the corrector folds the one half into the shift
    assign prod_shifted = halve_b_reg ? (prod_b_reg >>> (FRAC_W + 1)) : (prod_b_reg >>> FRAC_W);
    assign sum = ACC_W'(base_b_reg) + $signed(prod_shifted[ACC_W-1:0]);

    assign in_range = (&sum[ACC_W-1:VAL_W-1]) || (~|sum[ACC_W-1:VAL_W-1]);

    always_comb
    begin
        if (in_range)
        begin
            result = sum[VAL_W-1:0];
        end
        else if (sum[ACC_W-1])
        begin
            result = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

endmodule

// ===== dv/heun_second_order_state_step_core_tb.sv =====
// self-checking testbench for the heun state step core: directed table, then random phases
`timescale 1ns / 1ps

module heun_second_order_state_step_core_tb;
    import hss_pkg::*;

    localparam logic [STAGE_W-1:0] STAGE_RSVD = 2'd3;
    localparam logic [VAL_W-1:0]   VMAX       = 32'h7fffffff;
    localparam logic [VAL_W-1:0]   VMIN       = 32'h80000000;
    localparam int                 STALL_LIMIT = 5000;
    localparam int                 PHASE_WORDS = 50;

    typedef struct packed {
        logic [IDX_W-1:0] elem;
        logic [VAL_W-1:0] pos;
        logic [VAL_W-1:0] vel;
    } step_result_t;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   pos;
        logic [VAL_W-1:0]   vel;
        logic [VAL_W-1:0]   acc;
        logic               typed;
        logic [VAL_W-1:0]   exp_pos;
        logic [VAL_W-1:0]   exp_vel;
    } dir_row_t;

    // rows with typed results run at the reset time step of one
    dir_row_t dir_rows [16] = '{
        '{STAGE_PASS, 10'd0,    VMAX, VMIN, 32'h00005a5a, 1'b1, VMAX, VMIN},
        '{STAGE_RSVD, 10'd1023, VMIN, VMAX, 32'hffffffff, 1'b1, VMIN, VMAX},
        '{STAGE_PRED, 10'd5, 32'h00010000, 32'h00020000, 32'hffff0000,
          1'b1, 32'h00030000, 32'h00010000},
        // corrector right behind its predictor on the same element
        '{STAGE_CORR, 10'd5, 32'h00000000, 32'h00040000, 32'h00030000,
          1'b1, 32'h00040000, 32'h00030000},
        '{STAGE_PRED, 10'd1023, VMAX, VMAX, VMAX, 1'b1, VMAX, VMAX},
        '{STAGE_CORR, 10'd1023, VMAX, VMAX, VMAX, 1'b1, VMAX, VMAX},
        '{STAGE_PRED, 10'd0, VMIN, VMIN, VMIN, 1'b1, VMIN, VMIN},
        '{STAGE_CORR, 10'd0, VMIN, VMIN, VMIN, 1'b1, VMIN, VMIN},
        '{STAGE_PRED, 10'd2, 32'h00000000, 32'hffffffff, 32'h00000001,
          1'b1, 32'hffffffff, 32'h00000000},
        // half of minus one floors to minus one
        '{STAGE_CORR, 10'd2, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b1, 32'hffffffff, 32'hffffffff},
        '{STAGE_PRED, 10'd512, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 1'b0, '0, '0},
        '{STAGE_CORR, 10'd512, 32'hdeadbeef, 32'h01234567, 32'h89abcdef, 1'b0, '0, '0},
        '{STAGE_CORR, 10'd5,   32'h00000000, 32'hfffc0000, 32'h7fff0000, 1'b0, '0, '0},
        '{STAGE_PRED, 10'd341, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b0, '0, '0},
        '{STAGE_RSVD, 10'd682, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
          1'b1, 32'h55555555, 32'haaaaaaaa},
        '{STAGE_CORR, 10'd341, 32'h00000000, 32'haaaaaaaa, 32'h55555555, 1'b0, '0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [DT_W-1:0]       cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // element_index, position_in, velocity_in, acceleration_in
    logic [STAGE_W-1:0]    s_tuser;   // stage
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // element_out, position_out, velocity_out

    // predictor state
    logic [DT_W-1:0]         step_dt;
    logic signed [VAL_W-1:0] held_pos [ENTRIES];
    logic signed [VAL_W-1:0] held_vel [ENTRIES];
    logic signed [VAL_W-1:0] held_acc [ENTRIES];
    bit                      held_valid [ENTRIES];

    step_result_t expected_steps [$];
    int           mismatches;
    int           quiet_cycles;
    int           send_idle_pct;
    int           recv_stall_pct;

    heun_second_order_state_step_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [VAL_W-1:0] clamp32(longint v);
        if (v > longint'(32'sh7fffffff))
            return VMAX;
        if (v < -longint'(64'sh80000000))
            return VMIN;
        return v[VAL_W-1:0];
    endfunction

    function automatic step_result_t heun_advance(logic [STAGE_W-1:0] stage,
                                                  logic [IDX_W-1:0] idx,
                                                  logic signed [VAL_W-1:0] pos,
                                                  logic signed [VAL_W-1:0] vel,
                                                  logic signed [VAL_W-1:0] acc);
        step_result_t r;
        longint p;
        longint v;
        longint a;
        longint d;
        longint sp;
        longint sv;
        longint sa;
        p = pos;
        v = vel;
        a = acc;
        d = step_dt;
        r.elem = idx;
        r.pos  = pos;
        r.vel  = vel;
        if (stage == STAGE_PRED)
        begin
            held_pos[idx]   = pos;
            held_vel[idx]   = vel;
            held_acc[idx]   = acc;
            held_valid[idx] = 1'b1;
            r.pos = clamp32(p + ((v * d) >>> 16));
            r.vel = clamp32(v + ((a * d) >>> 16));
        end
        else if (stage == STAGE_CORR)
        begin
            sp = held_pos[idx];
            sv = held_vel[idx];
            sa = held_acc[idx];
            r.pos = clamp32(sp + (((sv + v) * d) >>> 17));
            r.vel = clamp32(sv + (((sa + a) * d) >>> 17));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // drives one word from a falling edge and returns at the falling edge after acceptance
    task automatic send_word(logic [STAGE_W-1:0] stage, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] pos, logic [VAL_W-1:0] vel,
                             logic [VAL_W-1:0] acc, logic typed,
                             logic [VAL_W-1:0] exp_pos, logic [VAL_W-1:0] exp_vel);
        step_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = stage;
        s_tdata  = {6'b0, acc, vel, pos, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = heun_advance(stage, idx, pos, vel, acc);
        if (typed)
        begin
            r.pos = exp_pos;
            r.vel = exp_vel;
        end
        expected_steps.push_back(r);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        s_tvalid = 1'b0;
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_time_step(logic [DT_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we  = 1'b0;
        step_dt = value;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VMAX;
            1: return VMIN;
            2: return '0;
            3: return '1;
            4, 5: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
            default: return $urandom;
        endcase
    endfunction

    // mostly predictor/corrector pairs on a few hot elements, some pass and reserved noise
    task automatic run_random(int count, bit hold_midway);
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   last_pred;
        logic [STAGE_W-1:0] stage;
        int                 roll;
        last_pred = '0;
        for (int n = 0; n < count; n++)
        begin
            if (hold_midway && n == count / 2)
                wait_quiet();
            roll = $urandom_range(0, 99);
            idx  = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 7))
                                        : IDX_W'($urandom_range(0, ENTRIES - 1));
            if (roll < 45)
                stage = STAGE_PRED;
            else if (roll < 80)
            begin
                stage = STAGE_CORR;
                if ($urandom_range(0, 99) < 60)
                    idx = last_pred;
                if (!held_valid[idx])
                    stage = STAGE_PRED;
            end
            else if (roll < 90)
                stage = STAGE_PASS;
            else
                stage = STAGE_RSVD;
            if (stage == STAGE_PRED)
                last_pred = idx;
            send_word(stage, idx, pick_value(), pick_value(), pick_value(), 1'b0, '0, '0);
        end
    endtask

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        step_result_t want;
        step_result_t got;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                got.elem = m_tdata[IDX_W-1:0];
                got.pos  = m_tdata[IDX_W +: VAL_W];
                got.vel  = m_tdata[IDX_W+VAL_W +: VAL_W];
                if (expected_steps.size() == 0)
                begin
                    report_mismatch("word with nothing pending, element", VAL_W'(got.elem),
                                    '0);
                end
                else
                begin
                    want = expected_steps.pop_front();
                    if (got.elem != want.elem)
                        report_mismatch("element", VAL_W'(got.elem), VAL_W'(want.elem));
                    if (got.pos != want.pos)
                        report_mismatch("position", got.pos, want.pos);
                    if (got.vel != want.vel)
                        report_mismatch("velocity", got.vel, want.vel);
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = STAGE_PASS;
        m_tready       = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        step_dt        = TIME_STEP_RESET;
        for (int i = 0; i < ENTRIES; i++)
            held_valid[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].stage, dir_rows[i].idx, dir_rows[i].pos, dir_rows[i].vel,
                      dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].exp_pos,
                      dir_rows[i].exp_vel);

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_quiet();
            case (ph)
                0: set_time_step('0);
                1: set_time_step('1);
                2: set_time_step(24'h008000);
                3: set_time_step(24'h000001);
                4: set_time_step(TIME_STEP_RESET);
                default: set_time_step(DT_W'($urandom_range(0, 24'hffffff)));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            run_random(PHASE_WORDS, ph == 3);
        end

        s_tvalid = 1'b0;
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_steps.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hss_pkg.sv
hdl/hss_lane.sv
hdl/heun_second_order_state_step_core.sv
dv/heun_second_order_state_step_core_tb.sv
